// ===== hw/rtl/ipv4_header_insert_assert.svh =====
// Assertion macros shared by the IPv4 header insertion RTL.
// Each macro expects i_clk and i_rst_n in the scope that uses it.
`ifndef IPV4_HEADER_INSERT_ASSERT_SVH
`define IPV4_HEADER_INSERT_ASSERT_SVH

// Plain property, checked on every rising edge outside reset.
`define IHI_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Same-cycle implication.
`define IHI_ASSERT_IMP(label, cond, conseq, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (conseq)) \
        else $error(msg);

// Next-cycle implication.
`define IHI_ASSERT_NXT(label, cond, conseq, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (conseq)) \
        else $error(msg);

`endif

// ===== hw/rtl/ihi_pkg.sv =====
// Shared types and constants for the IPv4 header insertion block.
// No dependencies; used by every module under hw/rtl.
package ihi_pkg;

    localparam int PortCount   = 4;
    localparam int MtuCount    = 4;
    localparam int PortSelW    = $clog2(MtuCount);
    localparam int CfgIndexW   = 3;
    localparam int CfgDataW    = 16;

    localparam logic [15:0] MtuReset     = 16'd1500;
    localparam logic [15:0] HdrBytes     = 16'd20;
    localparam logic [7:0]  VerIhl       = 8'h45;
    localparam logic [7:0]  TtlDefault   = 8'd64;
    localparam logic [15:0] DfFlag       = 16'h4000;
    // 0x4500 (version/IHL/TOS) + 0x4000 (DF) + 0x4000 (TTL 64, protocol 0)
    localparam logic [15:0] CsumConst    = 16'hC500;

    localparam int          SumW         = 19;
    localparam int          WordCount    = 5;
    localparam logic [2:0]  LastWord     = 3'(WordCount - 1);

    // Must be a power of two: pointers wrap naturally.
    localparam int QueueDepth = 2;
    localparam int QPtrW      = $clog2(QueueDepth);
    localparam int QCntW      = $clog2(QueueDepth + 1);

    typedef enum logic [CfgIndexW-1:0] {
        CfgPortMask = 3'd0,
        CfgMtuPort0 = 3'd1,
        CfgMtuPort1 = 3'd2,
        CfgMtuPort2 = 3'd3,
        CfgMtuPort3 = 3'd4
    } t_cfg_index;

    typedef enum logic [1:0] {
        StOk      = 2'd0,
        StBadPort = 2'd1,
        StOverMtu = 2'd2,
        StNoRoom  = 2'd3
    } t_status;

    // One classified packet, waiting for the emitter.
    typedef struct packed {
        t_status          status;
        logic [15:0]      ip_len;
        logic [15:0]      ident;
        logic [7:0]       protocol;
        logic [31:0]      ip_src;
        logic [31:0]      ip_dst;
        logic [SumW-1:0]  csum_sum;
    } t_desc;

    typedef struct packed {
        logic  valid;
        t_desc desc;
    } t_q_head;

endpackage

// ===== hw/rtl/ihi_front.sv =====
// Front end: configuration registers, packet checks, identification counter
// and the unfolded header sum. Depends on ihi_pkg.
module ihi_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [ihi_pkg::CfgIndexW-1:0] i_cfg_index,
    input  logic [ihi_pkg::CfgDataW-1:0]  i_cfg_data,
    input  logic                         i_accept,
    input  logic [15:0]                  i_payload_length,
    input  logic [7:0]                   i_protocol_number,
    input  logic [31:0]                  i_source_address,
    input  logic [31:0]                  i_destination_address,
    input  logic [7:0]                   i_egress_port,
    input  logic [15:0]                  i_headroom_bytes,
    output ihi_pkg::t_desc               o_desc
);

    logic [ihi_pkg::MtuCount-1:0] r_port_started;
    logic [15:0]                  r_mtu [ihi_pkg::MtuCount];
    logic [15:0]                  r_ident;
    logic [15:0]                  n_ident;

    logic                         cfg_we;
    logic [ihi_pkg::CfgIndexW-1:0] mtu_sel_full;
    logic [ihi_pkg::PortSelW-1:0] mtu_sel;
    logic [ihi_pkg::PortSelW-1:0] port_sel;
    logic                         port_bad;
    logic [16:0]                  total_ext;
    logic                         over_mtu;
    ihi_pkg::t_status             status;

    assign o_cfg_ready  = 1'b1;
    assign cfg_we       = i_cfg_valid;
    assign mtu_sel_full = i_cfg_index - ihi_pkg::CfgMtuPort0;
    assign mtu_sel      = mtu_sel_full[ihi_pkg::PortSelW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_port_started <= '0;
            for (int p = 0; p < ihi_pkg::MtuCount; p++) begin
                r_mtu[p] <= ihi_pkg::MtuReset;
            end
        end else if (cfg_we) begin
            unique case (i_cfg_index) inside
                ihi_pkg::CfgPortMask: begin
                    r_port_started <= i_cfg_data[ihi_pkg::MtuCount-1:0];
                end
                ihi_pkg::CfgMtuPort0, ihi_pkg::CfgMtuPort1,
                ihi_pkg::CfgMtuPort2, ihi_pkg::CfgMtuPort3: begin
                    r_mtu[mtu_sel] <= i_cfg_data;
                end
                default: begin
                    // unknown index: drop the write
                end
            endcase
        end
    end

    // Checks in priority order: port, length, headroom.
    assign port_sel  = i_egress_port[ihi_pkg::PortSelW-1:0];
    assign port_bad  = (i_egress_port >= 8'(ihi_pkg::PortCount)) || !r_port_started[port_sel];
    assign total_ext = {1'b0, i_payload_length} + {1'b0, ihi_pkg::HdrBytes};
    assign over_mtu  = total_ext[16] || (total_ext[15:0] > r_mtu[port_sel]);

    always_comb begin
        if (port_bad) begin
            status = ihi_pkg::StBadPort;
        end else if (over_mtu) begin
            status = ihi_pkg::StOverMtu;
        end else if (i_headroom_bytes < ihi_pkg::HdrBytes) begin
            status = ihi_pkg::StNoRoom;
        end else begin
            status = ihi_pkg::StOk;
        end
    end

    // Advance identification only on a packet that passes.
    assign n_ident = (i_accept && status == ihi_pkg::StOk) ? r_ident + 16'd1 : r_ident;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ident <= '0;
        end else begin
            r_ident <= n_ident;
        end
    end

    always_comb begin
        o_desc.status       = status;
        o_desc.ip_len       = total_ext[15:0];
        o_desc.ident        = r_ident;
        o_desc.protocol     = i_protocol_number;
        o_desc.ip_src       = i_source_address;
        o_desc.ip_dst       = i_destination_address;
        o_desc.csum_sum     = ihi_pkg::SumW'(ihi_pkg::CsumConst)
                            + ihi_pkg::SumW'(total_ext[15:0])
                            + ihi_pkg::SumW'(r_ident)
                            + ihi_pkg::SumW'(i_protocol_number)
                            + ihi_pkg::SumW'(i_source_address[31:16])
                            + ihi_pkg::SumW'(i_source_address[15:0])
                            + ihi_pkg::SumW'(i_destination_address[31:16])
                            + ihi_pkg::SumW'(i_destination_address[15:0]);
    end

endmodule

// ===== hw/rtl/ihi_queue.sv =====
// Short descriptor queue between the front end and the word emitter.
// Depends on ihi_pkg and ipv4_header_insert_assert.svh.
`include "ipv4_header_insert_assert.svh"

module ihi_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  ihi_pkg::t_desc   i_desc,
    output logic             o_full,
    input  logic             i_pop,
    output ihi_pkg::t_q_head o_head
);

    ihi_pkg::t_desc              r_slot [ihi_pkg::QueueDepth];
    logic [ihi_pkg::QPtrW-1:0]   r_wr_ptr;
    logic [ihi_pkg::QPtrW-1:0]   r_rd_ptr;
    logic [ihi_pkg::QCntW-1:0]   r_count;
    logic [ihi_pkg::QCntW-1:0]   n_count;
    logic                        do_push;
    logic                        do_pop;

    assign o_full      = (r_count == ihi_pkg::QCntW'(ihi_pkg::QueueDepth));
    assign o_head.valid = (r_count != '0);
    assign o_head.desc  = r_slot[r_rd_ptr];

    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_head.valid;

    always_comb begin
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + ihi_pkg::QCntW'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - ihi_pkg::QCntW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + ihi_pkg::QPtrW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + ihi_pkg::QPtrW'(1);
            end
            r_count <= n_count;
        end
    end

    `IHI_ASSERT(a_q_count_bound, r_count <= ihi_pkg::QCntW'(ihi_pkg::QueueDepth), "queue count above depth")
    `IHI_ASSERT_IMP(a_q_ptr_gap, r_count == '0, r_wr_ptr == r_rd_ptr, "empty queue with pointer gap")
    `IHI_ASSERT_IMP(a_q_full_ptrs, o_full, r_wr_ptr == r_rd_ptr, "full queue with pointer gap")

endmodule

// ===== hw/rtl/ihi_back.sv =====
// Back end: walks each passing descriptor into header words, turns a drop
// into one zero beat, folds the checksum and registers each output beat.
// Depends on ihi_pkg and ipv4_header_insert_assert.svh.
`include "ipv4_header_insert_assert.svh"

module ihi_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ihi_pkg::t_q_head i_head,
    output logic             o_q_pop,
    output logic             o_empty,
    input  logic             i_pop,
    output logic [1:0]       o_status,
    output logic [31:0]      o_header_word,
    output logic [2:0]       o_word_index,
    output logic             o_last
);

    logic        r_out_valid;
    logic [1:0]  r_out_status;
    logic [31:0] r_out_word;
    logic [2:0]  r_out_idx;
    logic        r_out_last;
    logic [2:0]  r_word_idx;
    logic [2:0]  n_word_idx;

    logic        load;
    logic        is_drop;
    logic        end_item;
    logic [16:0] fold1;
    logic [15:0] fold2;
    logic [15:0] csum;
    logic [31:0] word;

    assign load     = i_head.valid && (!r_out_valid || i_pop);
    assign is_drop  = (i_head.desc.status != ihi_pkg::StOk);
    assign end_item = is_drop || (r_word_idx == ihi_pkg::LastWord);
    assign o_q_pop  = load && end_item;

    // Two end-around folds bring the 19-bit sum into 16 bits.
    assign fold1 = {1'b0, i_head.desc.csum_sum[15:0]}
                 + 17'(i_head.desc.csum_sum[ihi_pkg::SumW-1:16]);
    assign fold2 = fold1[15:0] + 16'(fold1[16]);
    assign csum  = (fold2 == 16'hFFFF) ? fold2 : ~fold2;

    always_comb begin
        case (r_word_idx)
            3'd0:    word = {ihi_pkg::VerIhl, 8'h00, i_head.desc.ip_len};
            3'd1:    word = {i_head.desc.ident, ihi_pkg::DfFlag};
            3'd2:    word = {ihi_pkg::TtlDefault, i_head.desc.protocol, csum};
            3'd3:    word = i_head.desc.ip_src;
            default: word = i_head.desc.ip_dst;
        endcase
    end

    always_comb begin
        n_word_idx = r_word_idx;
        if (load) begin
            n_word_idx = end_item ? 3'd0 : r_word_idx + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_word_idx  <= '0;
        end else begin
            r_word_idx <= n_word_idx;
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_status <= i_head.desc.status;
            r_out_word   <= is_drop ? 32'd0 : word;
            r_out_idx    <= is_drop ? 3'd0 : r_word_idx;
            r_out_last   <= end_item;
        end
    end

    assign o_empty       = !r_out_valid;
    assign o_status      = r_out_status;
    assign o_header_word = r_out_word;
    assign o_word_index  = r_out_idx;
    assign o_last        = r_out_last;

    `IHI_ASSERT_IMP(a_drop_single, r_out_valid && r_out_status != ihi_pkg::StOk, r_out_last && r_out_word == 32'd0 && r_out_idx == 3'd0, "drop beat is not a single zero word")
    `IHI_ASSERT_IMP(a_idx_range, r_out_valid, r_out_idx <= ihi_pkg::LastWord, "word index past header end")
    `IHI_ASSERT_NXT(a_word_walk, r_out_valid && !r_out_last && i_pop, r_out_valid && r_out_idx == 3'($past(r_out_idx) + 3'd1), "header words not contiguous")

endmodule

// ===== hw/rtl/ipv4_header_insert.sv =====
// IPv4 header insertion: checks each packet descriptor and emits either one
// status beat (drop) or five big-endian header words with checksum.
// A descriptor passes through a queue slot and then the result register.
// The one 32-bit result register carries five header words for a passing
// packet and one status beat for a dropped one; a two-entry queue decouples input.
// Reset (synchronous, active low): queue empty, ports stopped, MTUs 1500, ident zero.
module ipv4_header_insert (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    // packet descriptor input
    input  logic        push,
    output logic        full,
    input  logic [15:0] i_payload_length,
    input  logic [7:0]  i_protocol_number,
    input  logic [31:0] i_source_address,
    input  logic [31:0] i_destination_address,
    input  logic [7:0]  i_egress_port,
    input  logic [15:0] i_headroom_bytes,
    // result beats
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  o_status,
    output logic [31:0] o_header_word,
    output logic [2:0]  o_word_index,
    output logic        o_last
);

    ihi_pkg::t_desc   front_desc;
    ihi_pkg::t_q_head q_head;
    logic             q_full;
    logic             q_pop;
    logic             in_accept;

    // An input beat is taken whenever the queue has room.
    assign full      = q_full;
    assign in_accept = push && !q_full;

    // Front: hold config, classify, stamp identification, pre-sum checksum.
    ihi_front u_front (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cfg_valid           (i_cfg_valid),
        .o_cfg_ready           (o_cfg_ready),
        .i_cfg_index           (i_cfg_index),
        .i_cfg_data            (i_cfg_data),
        .i_accept              (in_accept),
        .i_payload_length      (i_payload_length),
        .i_protocol_number     (i_protocol_number),
        .i_source_address      (i_source_address),
        .i_destination_address (i_destination_address),
        .i_egress_port         (i_egress_port),
        .i_headroom_bytes      (i_headroom_bytes),
        .o_desc                (front_desc)
    );

    // Queue: lets the front keep taking packets while the back drains words.
    ihi_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_desc  (front_desc),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_head  (q_head)
    );

    // Back: advance one header word per accepted result beat.
    ihi_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (q_head),
        .o_q_pop       (q_pop),
        .o_empty       (empty),
        .i_pop         (pop),
        .o_status      (o_status),
        .o_header_word (o_header_word),
        .o_word_index  (o_word_index),
        .o_last        (o_last)
    );

endmodule

// ===== sim/tb.sv =====
// Self-checking bench for ipv4_header_insert: drop status beats and IPv4 header words.
// Depends on ihi_pkg and the ipv4_header_insert RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Indexes past the last MTU register decode to nothing.
    localparam logic [2:0] CfgIndexSpare = 3'(ihi_pkg::CfgMtuPort3) + 3'd1;
    localparam int WatchdogLimit = 4000;
    localparam int PrintLimit    = 100;
    localparam int PktsPerPhase  = 22;

    typedef struct {
        logic [15:0] payload;
        logic [7:0]  proto;
        logic [31:0] src;
        logic [31:0] dst;
        logic [7:0]  port;
        logic [15:0] headroom;
    } t_pkt;

    typedef struct {
        ihi_pkg::t_status status;
        logic [31:0]      word;
        logic [2:0]       index;
        logic             last;
    } t_beat;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;
    logic        push = 1'b0;
    logic        full;
    logic [15:0] i_payload_length = '0;
    logic [7:0]  i_protocol_number = '0;
    logic [31:0] i_source_address = '0;
    logic [31:0] i_destination_address = '0;
    logic [7:0]  i_egress_port = '0;
    logic [15:0] i_headroom_bytes = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic [1:0]  o_status;
    logic [31:0] o_header_word;
    logic [2:0]  o_word_index;
    logic        o_last;

    ipv4_header_insert DUT (.*);

    // Packets waiting for the driver, and header beats waiting for the monitor.
    t_pkt  pkt_pending[$];
    t_beat beat_expect[$];
    t_pkt  cur_pkt;

    // Shadow of the block's registers and identification counter.
    logic [3:0]  port_mask = '0;
    logic [15:0] port_mtu[ihi_pkg::PortCount] = '{default: ihi_pkg::MtuReset};
    logic [15:0] ident_next = '0;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int quiet_cycles = 0;
    int err_count = 0;
    int pkts_in = 0;
    int beats_checked = 0;
    int drops = 0;
    int id_wraps = 0;
    int reg_writes = 0;

    // 10 ns clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic flag_mismatch(input string msg);
        err_count++;
        if (err_count <= PrintLimit) begin
            $display("tb: mismatch at %0t: %s", $realtime, msg);
        end
    endtask

    // Classify one packet in the block's check order, then build the header.
    function automatic void predict_header(input t_pkt p);
        logic [16:0]      total;
        logic [19:0]      sum;
        logic [15:0]      csum;
        logic [31:0]      w[ihi_pkg::WordCount];
        ihi_pkg::t_status st;
        total = {1'b0, p.payload} + {1'b0, ihi_pkg::HdrBytes};
        st = ihi_pkg::StOk;
        // Port first: out of range or not started.
        if (p.port >= ihi_pkg::PortCount) begin
            st = ihi_pkg::StBadPort;
        end else if (!port_mask[p.port[1:0]]) begin
            st = ihi_pkg::StBadPort;
        // Then total length against the port MTU and the 16-bit field.
        end else if (total > {1'b0, port_mtu[p.port[1:0]]} || total > 17'h0FFFF) begin
            st = ihi_pkg::StOverMtu;
        // Then headroom for the 20 header bytes.
        end else if (p.headroom < ihi_pkg::HdrBytes) begin
            st = ihi_pkg::StNoRoom;
        end
        if (st != ihi_pkg::StOk) begin
            // A drop is a single zero beat; the identification holds.
            beat_expect.push_back('{st, 32'h0, 3'd0, 1'b1});
            drops++;
            return;
        end
        w[0] = {ihi_pkg::VerIhl, 8'h00, total[15:0]};
        w[1] = {ident_next, ihi_pkg::DfFlag};
        w[2] = {ihi_pkg::TtlDefault, p.proto, 16'h0000};
        w[3] = p.src;
        w[4] = p.dst;
        sum = '0;
        for (int k = 0; k < ihi_pkg::WordCount; k++) begin
            sum = sum + w[k][31:16] + w[k][15:0];
        end
        while (sum > 20'h0FFFF) begin
            sum = sum[15:0] + sum[19:16];
        end
        // An all-ones sum keeps 0xFFFF instead of complementing to zero.
        csum = (sum[15:0] == 16'hFFFF) ? 16'hFFFF : ~sum[15:0];
        w[2][15:0] = csum;
        if (ident_next == 16'hFFFF) begin
            id_wraps++;
        end
        ident_next = ident_next + 16'd1;
        for (int k = 0; k < ihi_pkg::WordCount; k++) begin
            beat_expect.push_back('{ihi_pkg::StOk, w[k], 3'(k), k == ihi_pkg::WordCount - 1});
        end
    endfunction

    // Driver: hold a beat while full, otherwise advance to the next packet or idle.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                predict_header(cur_pkt);
                pkts_in++;
            end
            if (!push || !full) begin
                if (pkt_pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    cur_pkt = pkt_pending.pop_front();
                    i_payload_length      <= cur_pkt.payload;
                    i_protocol_number     <= cur_pkt.proto;
                    i_source_address      <= cur_pkt.src;
                    i_destination_address <= cur_pkt.dst;
                    i_egress_port         <= cur_pkt.port;
                    i_headroom_bytes      <= cur_pkt.headroom;
                    push <= 1'b1;
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    task automatic check_beat;
        t_beat want;
        if (beat_expect.size() == 0) begin
            flag_mismatch($sformatf("beat with nothing expected, word %h", o_header_word));
            return;
        end
        want = beat_expect.pop_front();
        beats_checked++;
        if (o_status !== want.status) begin
            flag_mismatch($sformatf("beat %0d status %0d, want %0d",
                                    beats_checked, o_status, want.status));
        end
        if (o_header_word !== want.word) begin
            flag_mismatch($sformatf("beat %0d word %h, want %h",
                                    beats_checked, o_header_word, want.word));
        end
        if (o_word_index !== want.index) begin
            flag_mismatch($sformatf("beat %0d index %0d, want %0d",
                                    beats_checked, o_word_index, want.index));
        end
        if (o_last !== want.last) begin
            flag_mismatch($sformatf("beat %0d last %b, want %b",
                                    beats_checked, o_last, want.last));
        end
    endtask

    // Monitor: check every popped beat, then stall or pop at random.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                check_beat();
            end
            pop <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: end the run when no beat moves on any channel for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WatchdogLimit) begin
            $display("tb: watchdog, %0d cycles without a beat", quiet_cycles);
            $display("tb: done, errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Raise the write, wait for ready, and track the register in the shadow.
    // Valid stays high for back-to-back writes; the caller lowers it.
    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        reg_writes++;
        case (idx)
            ihi_pkg::CfgPortMask: port_mask = val[3:0];
            ihi_pkg::CfgMtuPort0: port_mtu[0] = val;
            ihi_pkg::CfgMtuPort1: port_mtu[1] = val;
            ihi_pkg::CfgMtuPort2: port_mtu[2] = val;
            ihi_pkg::CfgMtuPort3: port_mtu[3] = val;
            default: ;
        endcase
    endtask

    // Wait until the driver has nothing left and every header beat is back.
    task automatic wait_drained;
        do begin
            @(posedge i_clk);
        end while (pkt_pending.size() != 0 || push || beat_expect.size() != 0);
    endtask

    function automatic void queue_pkt(input logic [15:0] payload, input logic [7:0] proto,
                                      input logic [31:0] src, input logic [31:0] dst,
                                      input logic [7:0] port, input logic [15:0] headroom);
        t_pkt p;
        p.payload  = payload;
        p.proto    = proto;
        p.src      = src;
        p.dst      = dst;
        p.port     = port;
        p.headroom = headroom;
        pkt_pending.push_back(p);
    endfunction

    // Build a packet that passes all checks on the current settings, or break it.
    function automatic t_pkt make_pkt(input bit well_formed);
        t_pkt        p;
        logic [7:0]  open_ports[$];
        logic [15:0] room;
        p.proto    = 8'($urandom_range(255));
        p.src      = $urandom;
        p.dst      = $urandom;
        p.payload  = 16'($urandom_range(65535));
        p.headroom = 16'($urandom_range(65535));
        p.port     = 8'($urandom_range(255));
        for (int n = 0; n < ihi_pkg::PortCount; n++) begin
            if (port_mask[n] && port_mtu[n] >= ihi_pkg::HdrBytes) begin
                open_ports.push_back(8'(n));
            end
        end
        if (open_ports.size() == 0) begin
            return p;
        end
        p.port     = open_ports[$urandom_range(open_ports.size() - 1)];
        p.headroom = 16'($urandom_range(65535, 20));
        room       = port_mtu[p.port[1:0]] - ihi_pkg::HdrBytes;
        // Land right on the MTU now and then.
        p.payload  = ($urandom_range(3) == 0) ? room : 16'($urandom_range(room));
        if (!well_formed) begin
            case ($urandom_range(3))
                0: p.port = 8'($urandom_range(255));
                1: p.port = 8'($urandom_range(ihi_pkg::PortCount - 1));
                2: p.payload = 16'($urandom_range(65535, room));
                default: p.headroom = 16'($urandom_range(19));
            endcase
        end
        return p;
    endfunction

    function automatic logic [15:0] pick_mtu;
        case ($urandom_range(5))
            0: return 16'd0;
            1: return ihi_pkg::HdrBytes;
            2: return ihi_pkg::HdrBytes + 16'd1;
            3: return ihi_pkg::MtuReset;
            4: return 16'hFFFF;
            default: return 16'($urandom_range(65535));
        endcase
    endfunction

    logic [31:0] ones_sum;
    int          phase_send[4] = '{0, 54, 0, 38};
    int          phase_recv[4] = '{0, 0, 54, 38};

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Out of reset no port is started: every packet drops on the port check.
        queue_pkt(16'd0, 8'd6, 32'h0A00_0001, 32'h0A00_0002, 8'd0, 16'd64);
        queue_pkt(16'd100, 8'd17, 32'h0A00_0003, 32'h0A00_0004, 8'd3, 16'd64);
        wait_drained();

        // Start all ports; upper data bits must be ignored. MTUs still at reset.
        write_reg(ihi_pkg::CfgPortMask, 16'hFFFF);
        i_cfg_valid <= 1'b0;
        queue_pkt(16'd1480, 8'd6, 32'hC0A8_0001, 32'hC0A8_0002, 8'd0, 16'd20);
        queue_pkt(16'd1481, 8'd6, 32'hC0A8_0001, 32'hC0A8_0002, 8'd0, 16'd20);
        queue_pkt(16'd1480, 8'd17, 32'hC0A8_0003, 32'hC0A8_0004, 8'd3, 16'd40);
        wait_drained();

        // MTU extremes per port; writes past the last register must change nothing.
        write_reg(ihi_pkg::CfgMtuPort0, 16'hFFFF);
        write_reg(ihi_pkg::CfgMtuPort1, 16'd0);
        write_reg(ihi_pkg::CfgMtuPort2, ihi_pkg::MtuReset);
        write_reg(ihi_pkg::CfgMtuPort3, ihi_pkg::HdrBytes + 16'd1);
        for (int n = 0; n < 3; n++) begin
            write_reg(CfgIndexSpare + 3'(n), 16'($urandom_range(65535)));
        end
        i_cfg_valid <= 1'b0;
        queue_pkt(16'd0, 8'd0, 32'h0000_0000, 32'h0000_0000, 8'd0, 16'd20);
        queue_pkt(16'd65515, 8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd0, 16'hFFFF);
        // Total length past 16 bits, with and without headroom.
        queue_pkt(16'd65516, 8'd17, 32'h0102_0304, 32'h0506_0708, 8'd0, 16'hFFFF);
        queue_pkt(16'hFFFF, 8'd6, 32'hAAAA_5555, 32'h5555_AAAA, 8'd0, 16'd0);
        // Zero MTU rejects even an empty payload.
        queue_pkt(16'd0, 8'd6, 32'h0A0A_0A0A, 32'h0B0B_0B0B, 8'd1, 16'd100);
        // Tiny MTU: one byte fits, two do not.
        queue_pkt(16'd1, 8'd1, 32'h7F00_0001, 32'h7F00_0001, 8'd3, 16'd20);
        queue_pkt(16'd2, 8'd1, 32'h7F00_0001, 32'h7F00_0001, 8'd3, 16'd20);
        // Headroom just short, and none at all.
        queue_pkt(16'd1480, 8'd17, 32'hC0A8_0101, 32'hC0A8_0102, 8'd2, 16'd19);
        queue_pkt(16'd0, 8'd17, 32'hC0A8_0101, 32'hC0A8_0102, 8'd2, 16'd0);
        queue_pkt(16'd1480, 8'd1, 32'hE000_0001, 32'hFFFF_FFFF, 8'd2, 16'd20);
        queue_pkt(16'd1481, 8'd1, 32'hE000_0001, 32'hFFFF_FFFF, 8'd2, 16'd20);
        // Bad port wins over every later check.
        queue_pkt(16'hFFFF, 8'd6, 32'h0, 32'h0, 8'd4, 16'd0);
        queue_pkt(16'd0, 8'd6, 32'h0, 32'h0, 8'd255, 16'd100);
        queue_pkt(16'd100, 8'd6, 32'h0, 32'h0, 8'd128, 16'd100);
        // Over MTU wins over short headroom.
        queue_pkt(16'd2000, 8'd6, 32'h0, 32'h0, 8'd2, 16'd0);
        wait_drained();

        // Pick a destination that makes the header sum all ones.
        ones_sum = {16'h0, ihi_pkg::CsumConst} + {16'h0, ihi_pkg::HdrBytes}
                 + {16'h0, ident_next};
        ones_sum = ones_sum[15:0] + ones_sum[31:16];
        queue_pkt(16'd0, 8'd0, 32'h0, {16'h0, 16'hFFFF - ones_sum[15:0]}, 8'd0, 16'd20);
        queue_pkt(16'd0, 8'd0, 32'h0, {16'h0, 16'hFFFE - ones_sum[15:0]}, 8'd0, 16'd20);
        wait_drained();

        // Random phases: new settings each time, mostly clean packets, some broken.
        for (int ph = 0; ph < 4; ph++) begin
            if (ph == 0) begin
                write_reg(ihi_pkg::CfgPortMask, 16'h000F);
                for (int n = 0; n < ihi_pkg::PortCount; n++) begin
                    write_reg(3'(ihi_pkg::CfgMtuPort0) + 3'(n), 16'hFFFF);
                end
            end else begin
                write_reg(ihi_pkg::CfgPortMask, 16'($urandom_range(15, 1)));
                for (int n = 0; n < ihi_pkg::PortCount; n++) begin
                    write_reg(3'(ihi_pkg::CfgMtuPort0) + 3'(n), pick_mtu());
                end
            end
            i_cfg_valid <= 1'b0;
            send_idle_pct  = phase_send[ph];
            recv_stall_pct = phase_recv[ph];
            for (int n = 0; n < PktsPerPhase; n++) begin
                pkt_pending.push_back(make_pkt($urandom_range(99) < 75));
            end
            // Phase boundary: hold the sender until every beat is back.
            wait_drained();
        end

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (20) @(posedge i_clk);

        $display("tb: %0d packets, %0d beats checked, %0d drops, %0d id wraps",
                 pkts_in, beats_checked, drops, id_wraps);
        $display("tb: %0d register writes, %0d mismatches", reg_writes, err_count);
        if (err_count == 0 && beat_expect.size() == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule
